FILE: sv/farthest_point_sampler_core_assert.svh
// ----------------------------------------------------------------------------
// Farthest point sampler assertion macros
// Clocked, reset-qualified property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef FARTHEST_POINT_SAMPLER_CORE_ASSERT_SVH
`define FARTHEST_POINT_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication
`define FPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fps_pkg.sv
// ----------------------------------------------------------------------------
// Farthest point sampler package
// Shared types and fixed constants of the sampler core.
// ----------------------------------------------------------------------------
package fps_pkg;

  // Fixed field widths
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned DIM_CFG_W  = 3;
  localparam int unsigned IDX_OUT_W  = 10;
  localparam int unsigned DIST_W     = 64;
  localparam int unsigned SQ_LIMIT_W = 32;

  // Selection limits and reset values
  localparam logic [CFG_W-1:0]     SEL_LIMIT       = 7'd64;
  localparam logic [DIM_CFG_W-1:0] DIM_COUNT_RST   = 3'd2;
  localparam logic [CFG_W-1:0]     SELECT_COUNT_RST = 7'd16;

  // Cycles between the last issued point and a settled pick
  localparam logic [2:0] PIPE_DRAIN = 3'd5;

  typedef enum logic [0:0] {
    REG_DIM_COUNT    = 1'b0,
    REG_SELECT_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT,
    ST_FETCH
  } fps_state_e;

  typedef struct packed {
    logic load_en;
    logic clear;
    logic issue;
    logic centroid;
    logic first_round;
    logic fetch_pick;
    logic latch_prev;
  } fps_cmd_t;

endpackage

FILE: sv/farthest_point_sampler_core.sv
// ----------------------------------------------------------------------------
// Farthest point sampler core
// Loads a point set and emits the indices chosen by farthest point sampling.
// ----------------------------------------------------------------------------
// Usage:
//   Write dim_count (index 0) and select_count (index 1) on the cfg port while
//   busy_o is low. Present a point on coord_*_i with start_i high; it is taken
//   at a clock edge where busy_o is low, one point per cycle. point_last_i on
//   a point closes the set and busy_o rises on the next cycle.
//   Results come out one word at a time: result_valid_o is high for one cycle
//   with selected_index_o, and select_last_o marks the final word of the run.
//   The receiver cannot stall; each word must be taken when shown.
//   Each index follows one full pass over the point store, one point read per
//   cycle, and the drain of the distance pipeline.
//   After the final index busy_o falls and the store is empty again.
//   Points beyond MAX_POINTS are dropped. Reset empties the set and restores
//   dim_count 2 and select_count 16; no store clearing is needed.
// ----------------------------------------------------------------------------
module farthest_point_sampler_core import fps_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned MAX_DIM    = 4,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [COORD_BITS-1:0] coord_a_i,
  input  logic [COORD_BITS-1:0] coord_b_i,
  input  logic [COORD_BITS-1:0] coord_c_i,
  input  logic [COORD_BITS-1:0] coord_d_i,
  input  logic                  point_last_i,
  output logic                  result_valid_o,
  output logic [IDX_OUT_W-1:0]  selected_index_o,
  output logic                  select_last_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS+1);

  logic [DIM_CFG_W-1:0]               dim_q;
  logic [CFG_W-1:0]                   sel_q;
  logic [DIM_CFG_W-1:0]               dims_eff;
  logic [3:0][COORD_BITS-1:0]         all_coords;
  logic [MAX_DIM-1:0][COORD_BITS-1:0] point;
  fps_cmd_t                           cmd;
  logic [IDX_W-1:0]                   issue_idx;
  logic [CNT_W-1:0]                   count;
  logic [IDX_W-1:0]                   pick;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_COUNT_RST;
      sel_q <= SELECT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DIM_COUNT:    dim_q <= cfg_data_i[DIM_CFG_W-1:0];
        REG_SELECT_COUNT: sel_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Clamp the dimension count into range
  always_comb begin
    dims_eff = dim_q;
    if (dim_q == '0) begin
      dims_eff = DIM_CFG_W'(1);
    end else if (dim_q > DIM_CFG_W'(MAX_DIM)) begin
      dims_eff = DIM_CFG_W'(MAX_DIM);
    end
  end

  assign all_coords = {coord_d_i, coord_c_i, coord_b_i, coord_a_i};
  assign point      = all_coords[MAX_DIM-1:0];

  fps_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .point_last_i   (point_last_i),
    .select_count_i (sel_q),
    .count_i        (count),
    .cmd_o          (cmd),
    .issue_idx_o    (issue_idx),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .select_last_o  (select_last_o)
  );

  fps_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .issue_idx_i (issue_idx),
    .dims_i      (dims_eff),
    .point_i     (point),
    .count_o     (count),
    .pick_o      (pick)
  );

  assign selected_index_o = IDX_OUT_W'(pick);

endmodule

FILE: sv/fps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/fps_ctrl.sv
// ----------------------------------------------------------------------------
// Farthest point sampler controller
// Sequences loading, the per-round store passes and result emission.
// ----------------------------------------------------------------------------
module fps_ctrl import fps_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              point_last_i,
  input  logic [CFG_W-1:0]                  select_count_i,
  input  logic [$clog2(MAX_POINTS+1)-1:0]   count_i,
  output fps_cmd_t                          cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0]     issue_idx_o,
  output logic                              busy_o,
  output logic                              result_valid_o,
  output logic                              select_last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS+1);
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  fps_state_e       state_q, state_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [2:0]       drain_q, drain_d;
  logic [CFG_W-1:0] r_q, r_d;
  logic [CFG_W-1:0] k_sel, k_run;
  logic             pass_end, run_last;

  // Clamp the selection count, then limit it to the points loaded
  always_comb begin
    k_sel = select_count_i;
    if (k_sel == '0) begin
      k_sel = CFG_W'(1);
    end else if (k_sel > SEL_LIMIT) begin
      k_sel = SEL_LIMIT;
    end
    k_run = (CMP_W'(count_i) < CMP_W'(k_sel)) ? CFG_W'(count_i) : k_sel;
  end

  assign pass_end = ((j_q + CNT_W'(1)) == count_i);
  assign run_last = ((r_q + CFG_W'(1)) == k_run);

  // Next state
  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    drain_d = drain_q;
    r_d     = r_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && point_last_i) begin
          state_d = ST_ISSUE;
          j_d     = '0;
          r_d     = '0;
        end
      end
      ST_ISSUE: begin
        j_d = j_q + CNT_W'(1);
        if (pass_end) begin
          state_d = ST_DRAIN;
          drain_d = '0;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 3'd1;
        if (drain_q == PIPE_DRAIN - 3'd1) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (run_last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FETCH;
          r_d     = r_q + CFG_W'(1);
        end
      end
      ST_FETCH: begin
        state_d = ST_ISSUE;
        j_d     = '0;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o             = '0;
    cmd_o.centroid    = (r_q == '0);
    cmd_o.first_round = (r_q == CFG_W'(1));
    busy_o            = 1'b1;
    result_valid_o    = 1'b0;
    select_last_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.load_en = start_i;
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        result_valid_o   = 1'b1;
        select_last_o    = run_last;
        cmd_o.fetch_pick = 1'b1;
        cmd_o.clear      = run_last;
      end
      ST_FETCH: begin
        cmd_o.latch_prev = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign issue_idx_o = j_q[IDX_W-1:0];

  // Hold state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      drain_q <= '0;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      drain_q <= drain_d;
      r_q     <= r_d;
    end
  end

endmodule

FILE: sv/fps_datapath.sv
// ----------------------------------------------------------------------------
// Farthest point sampler datapath
// Point store, coordinate sums, distance pipeline and pick tracking.
// ----------------------------------------------------------------------------
module fps_datapath import fps_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned MAX_DIM    = 4,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fps_cmd_t                               cmd_i,
  input  logic [$clog2(MAX_POINTS)-1:0]          issue_idx_i,
  input  logic [DIM_CFG_W-1:0]                   dims_i,
  input  logic [MAX_DIM-1:0][COORD_BITS-1:0]     point_i,
  output logic [$clog2(MAX_POINTS+1)-1:0]        count_o,
  output logic [$clog2(MAX_POINTS)-1:0]          pick_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS+1);
  localparam int unsigned SUM_W = COORD_BITS + IDX_W;
  localparam int unsigned PT_W  = MAX_DIM * COORD_BITS;
  localparam int unsigned PW    = 2 * COORD_BITS + 4;
  localparam int unsigned TW    = CNT_W + 1 + COORD_BITS;
  localparam int unsigned DW    = TW + 1;
  localparam int unsigned QW    = (DW > SQ_LIMIT_W) ? SQ_LIMIT_W : DW;
  localparam int unsigned ACC_W = DIST_W + 2;

  logic [CNT_W-1:0]                 cnt_q;
  logic signed [SUM_W-1:0]          sum_q [MAX_DIM];
  logic [MAX_DIM-1:0][COORD_BITS-1:0] prev_q;
  logic                             store_en;
  logic [MAX_DIM-1:0][COORD_BITS-1:0] rdata;
  logic [IDX_W-1:0]                 raddr;

  logic                             va_q, v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0]                 ia_q, i1_q, i2_q, i3_q, i4_q;
  logic signed [TW-1:0]             p1_q [MAX_DIM];
  logic                             sat2_q [MAX_DIM];
  logic [QW-1:0]                    q2_q [MAX_DIM];
  logic [DIST_W-1:0]                sq3_q [MAX_DIM];
  logic [DIST_W-1:0]                acc4_q;

  logic signed [CNT_W:0]            mfac;
  logic signed [TW-1:0]             prod [MAX_DIM];
  logic signed [DW-1:0]             sub_v [MAX_DIM];
  logic signed [DW-1:0]             diff [MAX_DIM];
  logic [DW-1:0]                    mag [MAX_DIM];
  logic [2*QW-1:0]                  sq_full [MAX_DIM];
  logic [ACC_W-1:0]                 acc;

  logic [PW-1:0]                    old_min, new_min;
  logic                             min_we;
  logic [DIST_W-1:0]                best_q;
  logic [IDX_W-1:0]                 pick_q;

  assign store_en = cmd_i.load_en && (cnt_q != CNT_W'(MAX_POINTS));
  assign raddr    = cmd_i.fetch_pick ? pick_q : issue_idx_i;
  assign count_o  = cnt_q;
  assign pick_o   = pick_q;

  // Point store
  fps_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (point_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Count and sum loaded points, drop them once the store is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int d = 0; d < MAX_DIM; d++) begin
        sum_q[d] <= '0;
      end
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
      for (int d = 0; d < MAX_DIM; d++) begin
        sum_q[d] <= '0;
      end
    end else if (store_en) begin
      cnt_q <= cnt_q + CNT_W'(1);
      for (int d = 0; d < MAX_DIM; d++) begin
        sum_q[d] <= sum_q[d] + SUM_W'(signed'(point_i[d]));
      end
    end
  end

  // Hold the last picked point for the pair pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_prev) begin
      prev_q <= rdata;
    end
  end

  // Stage one: scale by point count in the centroid pass
  always_comb begin
    mfac = cmd_i.centroid ? signed'({1'b0, cnt_q}) : (CNT_W+1)'(1);
    for (int d = 0; d < MAX_DIM; d++) begin
      prod[d] = mfac * signed'(rdata[d]);
    end
  end

  // Stage two: subtract the reference, take magnitude, mask unused lanes
  always_comb begin
    for (int d = 0; d < MAX_DIM; d++) begin
      sub_v[d] = cmd_i.centroid ? DW'(sum_q[d]) : DW'(signed'(prev_q[d]));
      diff[d]  = DW'(p1_q[d]) - sub_v[d];
      mag[d]   = diff[d][DW-1] ? DW'(-diff[d]) : DW'(diff[d]);
      if (d >= int'(dims_i)) begin
        mag[d] = '0;
      end
    end
  end

  // Stage three: square, saturating oversized terms
  always_comb begin
    for (int d = 0; d < MAX_DIM; d++) begin
      sq_full[d] = q2_q[d] * q2_q[d];
    end
  end

  // Stage four: sum lanes, saturate at all ones
  always_comb begin
    acc = '0;
    for (int d = 0; d < MAX_DIM; d++) begin
      acc = acc + ACC_W'(sq3_q[d]);
    end
  end

  // Distance pipeline
  always_ff @(posedge clk_i) begin
    ia_q <= issue_idx_i;
    i1_q <= ia_q;
    i2_q <= i1_q;
    i3_q <= i2_q;
    i4_q <= i3_q;
    for (int d = 0; d < MAX_DIM; d++) begin
      p1_q[d]   <= prod[d];
      sat2_q[d] <= ((mag[d] >> QW) != '0);
      q2_q[d]   <= mag[d][QW-1:0];
      sq3_q[d]  <= sat2_q[d] ? {DIST_W{1'b1}} : DIST_W'(sq_full[d]);
    end
    acc4_q <= ((acc >> DIST_W) != '0) ? {DIST_W{1'b1}} : acc[DIST_W-1:0];
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      va_q <= cmd_i.issue;
      v1_q <= va_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Least distance store, read one stage ahead of the update
  fps_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (min_we),
    .waddr_i (i4_q),
    .wdata_i (new_min),
    .raddr_i (i3_q),
    .rdata_o (old_min)
  );

  always_comb begin
    new_min = acc4_q[PW-1:0];
    if (!cmd_i.first_round && (old_min < acc4_q[PW-1:0])) begin
      new_min = old_min;
    end
    min_we = v4_q && !cmd_i.centroid;
  end

  // Track nearest-to-centroid or farthest point, lowest index on ties
  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      if (cmd_i.centroid) begin
        if ((i4_q == '0) || (acc4_q < best_q)) begin
          best_q <= acc4_q;
          pick_q <= i4_q;
        end
      end else begin
        if ((i4_q == '0) || (DIST_W'(new_min) > best_q)) begin
          best_q <= DIST_W'(new_min);
          pick_q <= i4_q;
        end
      end
    end
  end

endmodule

FILE: sv/fps_checker.sv
// ----------------------------------------------------------------------------
// Farthest point sampler checker
// Port-level assertions on run sequencing, bound to the core.
// ----------------------------------------------------------------------------
`include "farthest_point_sampler_core_assert.svh"

module fps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic point_last_i,
  input logic result_valid_o,
  input logic select_last_o
);

  // A closing point starts a run
  `FPS_ASSERT_NEXT(a_last_starts_run, start_i && !busy_o && point_last_i, busy_o, "run did not start")
  // An ordinary point keeps loading
  `FPS_ASSERT_NEXT(a_load_stays_idle, start_i && !busy_o && !point_last_i, !busy_o, "left load early")
  // Words only appear inside a run
  `FPS_ASSERT_NOW(a_result_in_run, result_valid_o, busy_o, "word outside run")
  // Each pick needs a full pass, so words never come back to back
  `FPS_ASSERT_NEXT(a_result_spaced, result_valid_o, !result_valid_o, "words back to back")
  // The final word ends the run
  `FPS_ASSERT_NEXT(a_last_ends_run, result_valid_o && select_last_o, !busy_o, "run did not end")

endmodule

bind farthest_point_sampler_core fps_checker u_fps_checker (.*);
